FILE: src/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg
// Types and constants shared by the grid ray marcher modules.
// ----------------------------------------------------------------------------
package grm_pkg;

	// input word: map write or ray cast
	typedef struct packed {
		logic        operation;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic        cell_open;
		logic [31:0] player_x;
		logic [31:0] player_y;
		logic [15:0] heading;
		logic [11:0] column;
	} item_t;

	// result word: one per cast
	typedef struct packed {
		logic [11:0] ray_column;
		logic [31:0] distance;
		logic [31:0] hit_x;
		logic [31:0] hit_y;
		logic [5:0]  hit_cell_x;
		logic [5:0]  hit_cell_y;
		logic [1:0]  status;
	} result_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [1:0] ST_WALL    = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 3'd6;

	// quarter sine polynomial, Q30
	localparam logic [30:0] SIN_A = 31'd1686629713;
	localparam logic [29:0] SIN_B = 30'd688904866;
	localparam logic [26:0] SIN_C = 27'd76016977;
	localparam logic [31:0] TWELFTH_TURN = 32'd357913941;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	// one 0.1 pixel step in Q16.16: 65536 = 6553*10 + 6
	localparam logic [12:0] DIST_INC = 13'd6553;
	localparam logic [3:0]  FRAC_INC = 4'd6;
	localparam logic [3:0]  FRAC_START = 4'd5;

	// bit-serial divider size
	localparam int DIV_N_W = 44;
	localparam int DIV_D_W = 26;

	typedef enum logic [1:0] {DIV_ANG, DIV_X, DIV_Y} div_sel_t;

	typedef enum logic [2:0] {
		MUL_NONE, MUL_UU, MUL_CU2, MUL_BU2, MUL_AU, MUL_KX, MUL_KY
	} mul_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_WR_READ, S_WR_WRITE, S_ANG_GO, S_ANG_WAIT, S_TRIG_LOAD,
		S_MUL_U, S_MUL_C, S_MUL_B, S_MUL_A, S_MUL_SAVE, S_K_X, S_K_Y, S_K_SAVE,
		S_DIVX_GO, S_DIVX_WAIT, S_DIVY_GO, S_DIVY_WAIT,
		S_LOOK, S_TEST, S_ADV, S_DELTA, S_MOVE, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     wr_sel;
		logic     map_write;
		logic     div_start;
		div_sel_t div_sel;
		logic     trig_load;
		logic     trig_pass;
		mul_op_t  mul_op;
		logic     trig_save;
		logic     k_save_x;
		logic     k_save_y;
		logic     march_init;
		logic     step_adv;
		logic     step_delta;
		logic     step_move;
		logic     finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic op_cast;
		logic outside;
		logic wall;
		logic last;
	} stat_t;

endpackage

FILE: src/grid_ray_marcher_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_marcher_unit
// Grid map ray marcher: keeps a wall bitmap and casts one ray per cast word.
// ----------------------------------------------------------------------------
//  channel  | signals                               | transfer
//  ---------+---------------------------------------+--------------------------
//  input    | start, busy, item                     | start high, busy low
//  result   | result_valid, result                  | one cycle, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_index, data | valid and ready high
//
//  A map write keeps busy high for the row read and the row write.
//  A cast keeps busy high through the setup (three passes of the bit-serial
//  divider, two sine evaluations and the step products on the shared
//  multiplier), the test of the first sample, each further step (advance,
//  delta, move, map read, test) and the result cycle.
//  Reset clears the row valid bits of the map, so all cells read as wall at
//  once; no clearing pass is needed. busy stays high through the result cycle.
// ----------------------------------------------------------------------------
module grid_ray_marcher_unit #(
	parameter int MAP_WIDTH          = 64,
	parameter int MAP_HEIGHT         = 64,
	parameter int MAX_STEPS          = 65535,
	parameter int MAX_SCREEN_COLUMNS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  grm_pkg::item_t                 item,
	output logic                           result_valid,
	output grm_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	grm_pkg::cmd_t  cmd;
	grm_pkg::stat_t stat;

	// configuration words are always taken
	assign cfg_ready = 1'b1;

	grm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	grm_datapath #(
		.MAP_WIDTH          (MAP_WIDTH),
		.MAP_HEIGHT         (MAP_HEIGHT),
		.MAX_STEPS          (MAX_STEPS),
		.MAX_SCREEN_COLUMNS (MAX_SCREEN_COLUMNS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);
endmodule

FILE: src/grm_div.sv
// ----------------------------------------------------------------------------
// grm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grm_pkg::DIV_N_W-1:0]  dividend,
	input  logic [grm_pkg::DIV_D_W-1:0]  divisor,
	output logic                         done,
	output logic [grm_pkg::DIV_N_W-1:0]  quotient,
	output logic [grm_pkg::DIV_D_W-1:0]  remainder
);
	localparam int N = grm_pkg::DIV_N_W;
	localparam int D = grm_pkg::DIV_D_W;
	localparam int CNT_W = $clog2(N + 1);

	logic [N-1:0]     quo_q;
	logic [D-1:0]     rem_q;
	logic [D-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [D:0]       trial;
	logic [D+1:0]     diff;
	logic             ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[N-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = ~diff[D+1];
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(N);
		end else if (run_q) begin
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift in one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

FILE: src/grm_ctrl.sv
// ----------------------------------------------------------------------------
// grm_ctrl
// Sequencer for map writes, ray setup and the marching step loop.
// ----------------------------------------------------------------------------
module grm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  grm_pkg::stat_t stat,
	output grm_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           result_valid
);
	grm_pkg::state_t state_q, state_d;
	logic            pass_q, pass_d;

	// next state
	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		case (state_q)
			grm_pkg::S_IDLE: begin
				if (start) begin
					state_d = stat.op_cast ? grm_pkg::S_ANG_GO : grm_pkg::S_WR_READ;
				end
			end
			grm_pkg::S_WR_READ:  state_d = grm_pkg::S_WR_WRITE;
			grm_pkg::S_WR_WRITE: state_d = grm_pkg::S_IDLE;
			grm_pkg::S_ANG_GO:   state_d = grm_pkg::S_ANG_WAIT;
			grm_pkg::S_ANG_WAIT: begin
				if (stat.div_done) begin
					state_d = grm_pkg::S_TRIG_LOAD;
					pass_d  = 1'b0;
				end
			end
			grm_pkg::S_TRIG_LOAD: state_d = grm_pkg::S_MUL_U;
			grm_pkg::S_MUL_U:     state_d = grm_pkg::S_MUL_C;
			grm_pkg::S_MUL_C:     state_d = grm_pkg::S_MUL_B;
			grm_pkg::S_MUL_B:     state_d = grm_pkg::S_MUL_A;
			grm_pkg::S_MUL_A:     state_d = grm_pkg::S_MUL_SAVE;
			grm_pkg::S_MUL_SAVE: begin
				state_d = pass_q ? grm_pkg::S_K_X : grm_pkg::S_TRIG_LOAD;
				pass_d  = 1'b1;
			end
			grm_pkg::S_K_X:       state_d = grm_pkg::S_K_Y;
			grm_pkg::S_K_Y:       state_d = grm_pkg::S_K_SAVE;
			grm_pkg::S_K_SAVE:    state_d = grm_pkg::S_DIVX_GO;
			grm_pkg::S_DIVX_GO:   state_d = grm_pkg::S_DIVX_WAIT;
			grm_pkg::S_DIVX_WAIT: begin
				if (stat.div_done) begin
					state_d = grm_pkg::S_DIVY_GO;
				end
			end
			grm_pkg::S_DIVY_GO:   state_d = grm_pkg::S_DIVY_WAIT;
			grm_pkg::S_DIVY_WAIT: begin
				if (stat.div_done) begin
					state_d = grm_pkg::S_LOOK;
				end
			end
			grm_pkg::S_LOOK: state_d = grm_pkg::S_TEST;
			grm_pkg::S_TEST: begin
				if (stat.outside || stat.wall || stat.last) begin
					state_d = grm_pkg::S_DONE;
				end else begin
					state_d = grm_pkg::S_ADV;
				end
			end
			grm_pkg::S_ADV:   state_d = grm_pkg::S_DELTA;
			grm_pkg::S_DELTA: state_d = grm_pkg::S_MOVE;
			grm_pkg::S_MOVE:  state_d = grm_pkg::S_LOOK;
			grm_pkg::S_DONE:  state_d = grm_pkg::S_IDLE;
			default:          state_d = grm_pkg::S_IDLE;
		endcase
	end

	// decode commands
	always_comb begin
		cmd           = '0;
		cmd.div_sel   = grm_pkg::DIV_ANG;
		cmd.mul_op    = grm_pkg::MUL_NONE;
		cmd.trig_pass = pass_q;
		busy          = 1'b1;
		result_valid  = 1'b0;
		case (state_q)
			grm_pkg::S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			grm_pkg::S_WR_READ:  cmd.wr_sel = 1'b1;
			grm_pkg::S_WR_WRITE: cmd.map_write = 1'b1;
			grm_pkg::S_ANG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = grm_pkg::DIV_ANG;
			end
			grm_pkg::S_ANG_WAIT:  cmd.div_sel = grm_pkg::DIV_ANG;
			grm_pkg::S_TRIG_LOAD: cmd.trig_load = 1'b1;
			grm_pkg::S_MUL_U:     cmd.mul_op = grm_pkg::MUL_UU;
			grm_pkg::S_MUL_C:     cmd.mul_op = grm_pkg::MUL_CU2;
			grm_pkg::S_MUL_B:     cmd.mul_op = grm_pkg::MUL_BU2;
			grm_pkg::S_MUL_A:     cmd.mul_op = grm_pkg::MUL_AU;
			grm_pkg::S_MUL_SAVE:  cmd.trig_save = 1'b1;
			grm_pkg::S_K_X:       cmd.mul_op = grm_pkg::MUL_KX;
			grm_pkg::S_K_Y: begin
				cmd.mul_op   = grm_pkg::MUL_KY;
				cmd.k_save_x = 1'b1;
			end
			grm_pkg::S_K_SAVE: cmd.k_save_y = 1'b1;
			grm_pkg::S_DIVX_GO: begin
				cmd.div_start  = 1'b1;
				cmd.div_sel    = grm_pkg::DIV_X;
				cmd.march_init = 1'b1;
			end
			grm_pkg::S_DIVX_WAIT: cmd.div_sel = grm_pkg::DIV_X;
			grm_pkg::S_DIVY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = grm_pkg::DIV_Y;
			end
			grm_pkg::S_DIVY_WAIT: cmd.div_sel = grm_pkg::DIV_Y;
			grm_pkg::S_LOOK:      cmd.div_sel = grm_pkg::DIV_ANG;
			grm_pkg::S_TEST:      cmd.finish = 1'b1;
			grm_pkg::S_ADV:       cmd.step_adv = 1'b1;
			grm_pkg::S_DELTA:     cmd.step_delta = 1'b1;
			grm_pkg::S_MOVE:      cmd.step_move = 1'b1;
			grm_pkg::S_DONE:      result_valid = 1'b1;
			default:              busy = 1'b1;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grm_pkg::S_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end
endmodule

FILE: src/grm_datapath.sv
// ----------------------------------------------------------------------------
// grm_datapath
// Map memory, configuration, sine unit, divider and the ray step registers.
// ----------------------------------------------------------------------------
module grm_datapath #(
	parameter int MAP_WIDTH          = 64,
	parameter int MAP_HEIGHT         = 64,
	parameter int MAX_STEPS          = 65535,
	parameter int MAX_SCREEN_COLUMNS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  grm_pkg::item_t                  item,
	input  logic                            cfg_valid,
	input  logic [grm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  grm_pkg::cmd_t                   cmd,
	output grm_pkg::stat_t                  stat,
	output grm_pkg::result_t                result
);
	localparam int CW = $clog2(MAP_WIDTH);
	localparam int RW = $clog2(MAP_HEIGHT);
	localparam int STEP_W = $clog2(MAX_STEPS);
	localparam longint DIST_MAX = ((longint'(MAX_STEPS) - 1) * 65536 + 5) / 10;
	localparam int DIST_W = $clog2(DIST_MAX + 1);
	localparam int ACC_W = DIST_W + 31;
	localparam int DX_W = ACC_W - 30;
	localparam int DELTA_W = 15;
	localparam int D = grm_pkg::DIV_D_W;
	localparam int N = grm_pkg::DIV_N_W;

	// configuration
	logic [31:0] offset_x_q, offset_y_q;
	logic [9:0]  cell_width_q, cell_height_q;
	logic [6:0]  map_columns_q, map_rows_q;
	logic [12:0] screen_columns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q       <= '0;
			offset_y_q       <= '0;
			cell_width_q     <= 10'd16;
			cell_height_q    <= 10'd16;
			map_columns_q    <= 7'd64;
			map_rows_q       <= 7'd64;
			screen_columns_q <= 13'd640;
		end else if (cfg_valid) begin
			case (cfg_index)
				grm_pkg::REG_OFFSET_X:       offset_x_q       <= cfg_data;
				grm_pkg::REG_OFFSET_Y:       offset_y_q       <= cfg_data;
				grm_pkg::REG_CELL_WIDTH:     cell_width_q     <= cfg_data[9:0];
				grm_pkg::REG_CELL_HEIGHT:    cell_height_q    <= cfg_data[9:0];
				grm_pkg::REG_MAP_COLUMNS:    map_columns_q    <= cfg_data[6:0];
				grm_pkg::REG_MAP_ROWS:       map_rows_q       <= cfg_data[6:0];
				grm_pkg::REG_SCREEN_COLUMNS: screen_columns_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// clamp configuration for use
	logic [D-1:0]  cw, ch;
	logic [8:0]    cols, rows;
	logic [13:0]   sc;
	logic [15:0]   ang_den;
	always_comb begin
		cw = {(cell_width_q == '0) ? 10'd1 : cell_width_q, 16'b0};
		ch = {(cell_height_q == '0) ? 10'd1 : cell_height_q, 16'b0};
		cols = ({2'b00, map_columns_q} < 9'(MAP_WIDTH)) ? {2'b00, map_columns_q}
			: 9'(MAP_WIDTH);
		rows = ({2'b00, map_rows_q} < 9'(MAP_HEIGHT)) ? {2'b00, map_rows_q}
			: 9'(MAP_HEIGHT);
		sc = (screen_columns_q == '0) ? 14'd1 : {1'b0, screen_columns_q};
		if (sc > 14'(MAX_SCREEN_COLUMNS)) begin
			sc = 14'(MAX_SCREEN_COLUMNS);
		end
		ang_den = 16'({sc, 2'b00}) + 16'({sc, 1'b0});
	end

	// capture the input word
	grm_pkg::item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// map memory: rows of cells, row valid bits stand for the wall reset
	logic [MAP_WIDTH-1:0] map_mem_q [MAP_HEIGHT];
	logic [MAP_HEIGHT-1:0] row_valid_q;
	logic [MAP_WIDTH-1:0] rd_row_s1, wr_row;
	logic                 rd_valid_s1;
	logic [RW-1:0]        rd_addr, wr_addr;
	logic [CW-1:0]        wr_bit;
	logic                 wr_in_range;
	logic [15:0]          mx_q, my_q;

	always_comb begin
		wr_addr     = RW'(item_q.cell_y);
		wr_bit      = CW'(item_q.cell_x);
		wr_in_range = (int'(item_q.cell_x) < MAP_WIDTH) && (int'(item_q.cell_y) < MAP_HEIGHT);
		rd_addr     = cmd.wr_sel ? wr_addr : my_q[RW-1:0];
		wr_row      = rd_valid_s1 ? rd_row_s1 : '0;
		wr_row[wr_bit] = item_q.cell_open;
	end

	always_ff @(posedge clk) begin
		rd_row_s1 <= map_mem_q[rd_addr];
		if (cmd.map_write && wr_in_range) begin
			map_mem_q[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= row_valid_q[rd_addr];
			if (cmd.map_write && wr_in_range) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// divider for the angle and the starting cells
	logic [32:0]  rx, ry;
	logic [N-1:0] div_num, div_quo;
	logic [D-1:0] div_den, div_rem;
	logic         div_done;
	always_comb begin
		rx = {1'b0, item_q.player_x} - {1'b0, offset_x_q};
		ry = {1'b0, item_q.player_y} - {1'b0, offset_y_q};
		case (cmd.div_sel)
			grm_pkg::DIV_X: begin
				div_num = N'(rx[31:0]);
				div_den = cw;
			end
			grm_pkg::DIV_Y: begin
				div_num = N'(ry[31:0]);
				div_den = ch;
			end
			default: begin
				div_num = {item_q.column, 32'b0};
				div_den = D'(ang_den);
			end
		endcase
	end

	grm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sine unit on a shared multiplier
	logic [31:0] angle_q, trig_angle, mul_a, mul_b;
	logic [16:0] u_q, u2_q, u_next;
	logic [63:0] prod_q;
	logic [30:0] sm_q, cm_q;
	logic        sneg_q, cneg_q;
	logic [43:0] kx_q, ky_q;

	always_comb begin
		trig_angle = cmd.trig_pass ? (angle_q + grm_pkg::QUARTER_TURN) : angle_q;
		u_next = trig_angle[30] ? (17'd65536 - {1'b0, trig_angle[29:14]})
			: {1'b0, trig_angle[29:14]};
		case (cmd.mul_op)
			grm_pkg::MUL_UU: begin
				mul_a = 32'(u_q);
				mul_b = 32'(u_q);
			end
			grm_pkg::MUL_CU2: begin
				mul_a = 32'(grm_pkg::SIN_C);
				mul_b = 32'(prod_q >> 16);
			end
			grm_pkg::MUL_BU2: begin
				mul_a = 32'(grm_pkg::SIN_B) - 32'(prod_q >> 16);
				mul_b = 32'(u2_q);
			end
			grm_pkg::MUL_AU: begin
				mul_a = 32'(grm_pkg::SIN_A) - 32'(prod_q >> 16);
				mul_b = 32'(u_q);
			end
			grm_pkg::MUL_KX: begin
				mul_a = 32'(cm_q);
				mul_b = 32'(grm_pkg::DIST_INC);
			end
			grm_pkg::MUL_KY: begin
				mul_a = 32'(sm_q);
				mul_b = 32'(grm_pkg::DIST_INC);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_done && (cmd.div_sel == grm_pkg::DIV_ANG)) begin
			angle_q <= {item_q.heading, 16'b0} - grm_pkg::TWELFTH_TURN + div_quo[31:0];
		end
		if (cmd.trig_load) begin
			u_q <= u_next;
		end
		if (cmd.mul_op != grm_pkg::MUL_NONE) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		if (cmd.mul_op == grm_pkg::MUL_CU2) begin
			u2_q <= 17'(prod_q >> 16);
		end
		if (cmd.trig_save) begin
			if (cmd.trig_pass) begin
				cm_q   <= 31'(prod_q >> 16);
				cneg_q <= trig_angle[31];
			end else begin
				sm_q   <= 31'(prod_q >> 16);
				sneg_q <= trig_angle[31];
			end
		end
		if (cmd.k_save_x) begin
			kx_q <= prod_q[43:0];
		end
		if (cmd.k_save_y) begin
			ky_q <= prod_q[43:0];
		end
	end

	// ray step registers
	logic [STEP_W-1:0]  n_q;
	logic [DIST_W-1:0]  dist_q;
	logic [3:0]         frac_q;
	logic [ACC_W-1:0]   accx_q, accy_q;
	logic [DX_W-1:0]    dx_q, dy_q, dxn, dyn;
	logic [DELTA_W-1:0] delx_q, dely_q;
	logic [D-1:0]       remx_q, remy_q;
	logic               negx_q, negy_q;
	logic               carry;
	logic [D:0]         sumx, sumy;
	logic [1:0]         status_q;
	logic               outside, wall, last;

	always_comb begin
		carry = (frac_q >= 4'd4);
		dxn   = accx_q[ACC_W-1:30];
		dyn   = accy_q[ACC_W-1:30];
		sumx  = {1'b0, remx_q} + (D + 1)'(delx_q);
		sumy  = {1'b0, remy_q} + (D + 1)'(dely_q);
		outside = negx_q || negy_q || (mx_q >= 16'(cols)) || (my_q >= 16'(rows));
		wall    = !(rd_valid_s1 && rd_row_s1[mx_q[CW-1:0]]);
		last    = (n_q == STEP_W'(MAX_STEPS - 1));
	end

	always_ff @(posedge clk) begin
		// start at step zero
		if (cmd.march_init) begin
			n_q    <= '0;
			dist_q <= '0;
			frac_q <= grm_pkg::FRAC_START;
			accx_q <= '0;
			accy_q <= '0;
			dx_q   <= '0;
			dy_q   <= '0;
			negx_q <= rx[32];
			negy_q <= ry[32];
		end
		// load starting cells
		if (div_done && (cmd.div_sel == grm_pkg::DIV_X)) begin
			mx_q   <= div_quo[15:0];
			remx_q <= div_rem;
		end
		if (div_done && (cmd.div_sel == grm_pkg::DIV_Y)) begin
			my_q   <= div_quo[15:0];
			remy_q <= div_rem;
		end
		// advance distance and products by one step
		if (cmd.step_adv) begin
			n_q    <= n_q + 1'b1;
			dist_q <= dist_q + DIST_W'(grm_pkg::DIST_INC) + DIST_W'(carry);
			frac_q <= carry ? (frac_q - 4'd4) : (frac_q + grm_pkg::FRAC_INC);
			accx_q <= accx_q + ACC_W'(kx_q) + (carry ? ACC_W'(cm_q) : '0);
			accy_q <= accy_q + ACC_W'(ky_q) + (carry ? ACC_W'(sm_q) : '0);
		end
		// take the pixel movement of this step
		if (cmd.step_delta) begin
			delx_q <= DELTA_W'(dxn - dx_q);
			dely_q <= DELTA_W'(dyn - dy_q);
			dx_q   <= dxn;
			dy_q   <= dyn;
		end
		// move the cell position, x grows unless cosine is negative
		if (cmd.step_move) begin
			if (!cneg_q) begin
				if (sumx >= {1'b0, cw}) begin
					remx_q <= D'(sumx - {1'b0, cw});
					mx_q   <= mx_q + 1'b1;
				end else begin
					remx_q <= D'(sumx);
				end
			end else if (remx_q >= D'(delx_q)) begin
				remx_q <= remx_q - D'(delx_q);
			end else if (mx_q == '0) begin
				negx_q <= 1'b1;
			end else begin
				mx_q   <= mx_q - 1'b1;
				remx_q <= remx_q + cw - D'(delx_q);
			end
			// y grows down, so a negative sine moves toward larger rows
			if (sneg_q) begin
				if (sumy >= {1'b0, ch}) begin
					remy_q <= D'(sumy - {1'b0, ch});
					my_q   <= my_q + 1'b1;
				end else begin
					remy_q <= D'(sumy);
				end
			end else if (remy_q >= D'(dely_q)) begin
				remy_q <= remy_q - D'(dely_q);
			end else if (my_q == '0) begin
				negy_q <= 1'b1;
			end else begin
				my_q   <= my_q - 1'b1;
				remy_q <= remy_q + ch - D'(dely_q);
			end
		end
		// latch the outcome
		if (cmd.finish) begin
			if (outside) begin
				status_q <= grm_pkg::ST_OUTSIDE;
			end else if (wall) begin
				status_q <= grm_pkg::ST_WALL;
			end else begin
				status_q <= grm_pkg::ST_LIMIT;
			end
		end
	end

	// status and result word
	always_comb begin
		stat.div_done = div_done;
		stat.op_cast  = (item.operation == grm_pkg::OP_CAST);
		stat.outside  = outside;
		stat.wall     = wall;
		stat.last     = last;

		result.ray_column = item_q.column;
		result.distance   = 32'(dist_q);
		result.hit_x = cneg_q ? (item_q.player_x - 32'(dx_q)) : (item_q.player_x + 32'(dx_q));
		result.hit_y = sneg_q ? (item_q.player_y + 32'(dy_q)) : (item_q.player_y - 32'(dy_q));
		result.hit_cell_x = (status_q == grm_pkg::ST_WALL) ? mx_q[5:0] : 6'd0;
		result.hit_cell_y = (status_q == grm_pkg::ST_WALL) ? my_q[5:0] : 6'd0;
		result.status     = status_q;
	end
endmodule
